FILE: rtl/shell_sort_engine_assert.svh
// ----------------------------------------------------------------------------
// shell_sort_engine_assert.svh
// Assertion macros for the shell sort engine. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SHELL_SORT_ENGINE_ASSERT_SVH
`define SHELL_SORT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define SSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shell_sort_engine: check failed");

// antecedent implies consequent in the next cycle
`define SSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shell_sort_engine: check failed");

`else

`define SSE_ASSERT_IMP(lbl, ante, cons)
`define SSE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants of the shell sort engine.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_res;
  } out_word_t;

endpackage

FILE: rtl/shell_sort_engine.sv
// ----------------------------------------------------------------------------
// shell_sort_engine
// Loads a set of signed words, sorts them ascending by Shell sort with
// halving gaps, and streams the sorted set back out.
// ----------------------------------------------------------------------------
// Words load one per cycle while busy is low; the word flagged last closes
// the set and raises busy. Words beyond MAX_ITEMS are dropped, though a
// dropped closing word still closes the set. All elements live in one
// single-port-write memory with a registered read. Within a pass each
// inserted element is fetched, moved down past every larger element one gap
// at a time, and compared and placed; each pass closes by halving the gap,
// over floor(log2(N)) passes. The sorted set then leaves at one word per
// cycle on out_strobe once the sort ends, N words with last_res on the final
// one; the receiver cannot stall and must take each word in the cycle it
// appears. busy falls in the cycle that the final word is on the output, so
// a new set may start loading while that word is still there.
// ----------------------------------------------------------------------------
module shell_sort_engine #(
  parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sse_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output sse_pkg::out_word_t out_word
);

  localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_OUTER = 6'b000010,
    ST_HOLD  = 6'b000100,
    ST_CMP   = 6'b001000,
    ST_PLACE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  logic [sse_pkg::DATA_W-1:0] mem [MAX_ITEMS];

  state_t                     state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           gap_r, gap_nxt;
  logic [CNT_W-1:0]           outer_r, outer_nxt;
  logic [CNT_W-1:0]           scan_r, scan_nxt;
  logic signed [sse_pkg::DATA_W-1:0] held_r, held_nxt;
  logic signed [sse_pkg::DATA_W-1:0] rdata_r;
  logic                       strobe_r, strobe_nxt;
  logic                       last_r, last_nxt;

  logic                       we;
  logic [IDX_W-1:0]           wr_addr;
  logic [sse_pkg::DATA_W-1:0] wr_data;
  logic [IDX_W-1:0]           rd_addr;
  logic [CNT_W-1:0]           scan_dn;
  logic [CNT_W-1:0]           scan_dn2;
  logic [CNT_W-1:0]           load_cnt;
  logic [CNT_W-1:0]           gap_half;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= $signed(mem[rd_addr]);
  end

  assign scan_dn  = scan_r - gap_r;
  assign scan_dn2 = scan_dn - gap_r;
  assign load_cnt = (cnt_r < MAX_C) ? cnt_r + ONE_C : cnt_r;
  assign gap_half = gap_r >> 1;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    gap_nxt    = gap_r;
    outer_nxt  = outer_r;
    scan_nxt   = scan_r;
    held_nxt   = held_r;
    strobe_nxt = 1'b0;
    last_nxt   = 1'b0;
    we         = 1'b0;
    wr_addr    = cnt_r[IDX_W-1:0];
    wr_data    = in_word.value;
    rd_addr    = outer_r[IDX_W-1:0];
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          we      = (cnt_r < MAX_C);
          cnt_nxt = load_cnt;
          if (in_word.last) begin
            gap_nxt = load_cnt >> 1;
            outer_nxt = load_cnt >> 1;
            state_nxt = ((load_cnt >> 1) == '0) ? ST_EMIT : ST_OUTER;
          end
        end
      end
      ST_OUTER: begin
        if (outer_r >= cnt_r) begin
          gap_nxt   = gap_half;
          outer_nxt = gap_half;
          if (gap_half == '0) begin
            state_nxt = ST_EMIT;
          end
        end else begin
          scan_nxt  = outer_r;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        held_nxt  = rdata_r;
        rd_addr   = scan_dn[IDX_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        we      = 1'b1;
        wr_addr = scan_r[IDX_W-1:0];
        if (rdata_r > held_r) begin
          wr_data  = rdata_r;
          scan_nxt = scan_dn;
          if (scan_dn >= gap_r) begin
            rd_addr = scan_dn2[IDX_W-1:0];
          end else begin
            state_nxt = ST_PLACE;
          end
        end else begin
          wr_data   = held_r;
          outer_nxt = outer_r + ONE_C;
          state_nxt = ST_OUTER;
        end
      end
      ST_PLACE: begin
        we        = 1'b1;
        wr_addr   = scan_r[IDX_W-1:0];
        wr_data   = held_r;
        outer_nxt = outer_r + ONE_C;
        state_nxt = ST_OUTER;
      end
      ST_EMIT: begin
        strobe_nxt = 1'b1;
        last_nxt   = (outer_r + ONE_C == cnt_r);
        outer_nxt  = outer_r + ONE_C;
        if (outer_r + ONE_C == cnt_r) begin
          cnt_nxt   = '0;
          outer_nxt = '0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= '0;
      gap_r    <= '0;
      outer_r  <= '0;
      scan_r   <= '0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      gap_r    <= gap_nxt;
      outer_r  <= outer_nxt;
      scan_r   <= scan_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  assign busy       = (state_r != ST_LOAD);
  assign out_strobe = strobe_r;
  assign out_word   = '{sorted_value: rdata_r, last_res: last_r};

`include "shell_sort_engine_assert.svh"

  `SSE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= MAX_C)
  `SSE_ASSERT_IMP(a_cmp_scan, state_r == ST_CMP, (gap_r != '0) && (scan_r >= gap_r))
  `SSE_ASSERT_NXT(a_close_busy, start && !busy && in_word.last, busy)
  `SSE_ASSERT_IMP(a_strobe_src, out_strobe, $past(state_r) == ST_EMIT)

endmodule

FILE: tb/sorted_stream_checker.sv
// ----------------------------------------------------------------------------
// sorted_stream_checker
// Watches the load and result channels of the shell sort engine. Every
// accepted word joins the open set until it holds MAX_ITEMS words. The
// word flagged last closes the set, which is then sorted here by halving-gap
// Shell sort and queued as the expected output stream. Each strobed result
// word is compared field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module sorted_stream_checker #(
  parameter int MAX_ITEMS = sse_pkg::MAX_ITEMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  sse_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  sse_pkg::out_word_t out_word,
  output int unsigned        mismatches,
  output int unsigned        pending
);

  logic signed [sse_pkg::DATA_W-1:0] set_vals [0:MAX_ITEMS-1];
  int                                set_len = 0;
  sse_pkg::out_word_t                sorted_words [$];
  sse_pkg::out_word_t                oldest;
  int unsigned                       mismatch_count = 0;
  int unsigned                       pending_count = 0;

  assign mismatches = mismatch_count;
  assign pending    = pending_count;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic sort_closed_set();
    int                                stride;
    int                                i;
    int                                j;
    logic signed [sse_pkg::DATA_W-1:0] hold;
    sse_pkg::out_word_t                w;
    for (stride = set_len / 2; stride > 0; stride = stride / 2) begin
      for (i = stride; i < set_len; i++) begin
        hold = set_vals[i];
        j = i;
        while (j >= stride && set_vals[j-stride] > hold) begin
          set_vals[j] = set_vals[j-stride];
          j -= stride;
        end
        set_vals[j] = hold;
      end
    end
    for (i = 0; i < set_len; i++) begin
      w.sorted_value = set_vals[i];
      w.last_res     = (i == set_len - 1);
      sorted_words.push_back(w);
    end
    set_len = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      set_len = 0;
      sorted_words.delete();
    end else begin
      if (out_strobe) begin
        if (sorted_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d last %0b",
                                    out_word.sorted_value, out_word.last_res));
        end else begin
          oldest = sorted_words.pop_front();
          if (out_word.sorted_value !== oldest.sorted_value)
            report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                      out_word.sorted_value, oldest.sorted_value));
          if (out_word.last_res !== oldest.last_res)
            report_mismatch($sformatf("last_res %0b, expected %0b",
                                      out_word.last_res, oldest.last_res));
        end
      end
      if (start && !busy) begin
        if (set_len < MAX_ITEMS) begin
          set_vals[set_len] = in_word.value;
          set_len++;
        end
        if (in_word.last)
          sort_closed_set();
      end
    end
    pending_count <= sorted_words.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives sets of signed words into the shell sort engine in bursts with
// random gaps: a directed opening with extreme values, duplicates and
// single-word sets, then random sets, mostly small, with a few full and
// overflowing ones. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_ITEMS     = sse_pkg::MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS  = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 50;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  sse_pkg::in_word_t  in_word = '0;
  logic               out_strobe;
  sse_pkg::out_word_t out_word;
  int unsigned        mismatches;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  int                 burst_left = 0;
  int                 loaded_items = 0;
  int                 set_index;
  int                 set_size;
  int                 k;
  bit                 narrow;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  shell_sort_engine #(.MAX_ITEMS(MAX_ITEMS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  sorted_stream_checker #(.MAX_ITEMS(MAX_ITEMS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic logic signed [sse_pkg::DATA_W-1:0] random_value(input bit tight);
    if (tight)
      return $signed($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'sh8000_0000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 4) - 2;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic signed [sse_pkg::DATA_W-1:0] value,
                           input logic last);
    start   <= 1'b1;
    in_word <= {value, last};
    @(posedge clk);
    while (busy) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start   <= 1'b0;
      in_word <= {$urandom, 1'($urandom_range(0, 1))};
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 10);
    end
  endtask

  // hold off until every expected word has come back
  task automatic drain_results();
    if (start)
      start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b1);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh0000_0000, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b1);
    send_word(32'sd5, 1'b0);
    send_word(-32'sd5, 1'b1);
    send_word(-32'sd7, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sd7, 1'b1);
    repeat (3) send_word(32'sh5555_AAAA, 1'b0);
    send_word(32'sh5555_AAAA, 1'b1);
    drain_results();

    set_index = 0;
    while (loaded_items < RANDOM_ITEMS) begin
      if (set_index == 0)
        set_size = MAX_ITEMS;
      else if (set_index == 3)
        set_size = MAX_ITEMS + 3;
      else if ($urandom_range(0, 29) == 0)
        set_size = $urandom_range(MAX_ITEMS - 1, MAX_ITEMS + 6);
      else
        set_size = $urandom_range(1, 12);
      narrow = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0)
        drain_results();
      for (k = 0; k < set_size; k++)
        send_word(random_value(narrow), k == set_size - 1);
      loaded_items += (set_size < MAX_ITEMS) ? set_size : MAX_ITEMS;
      set_index++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
